// ----- hdl/fmpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, sizes and match functions for the first-match packet classifier.
package fmpc_pkg;

  localparam int MAX_RULES = 256;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int CFG_W     = 9;
  localparam int RIDX_W    = 8;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rule_index;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [5:0]  len_a;
    logic [5:0]  len_b;
    logic [15:0] port_a_low;
    logic [15:0] port_a_high;
    logic [15:0] port_b_low;
    logic [15:0] port_b_high;
    logic [7:0]  proto_low;
    logic [7:0]  proto_high;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [8:0] rule_number;
  } out_item_t;

  // Stored rule; prefix lengths are kept as expanded masks.
  // For a classify transaction the same layout carries the packet key in
  // the addr and low fields.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] sp_lo;
    logic [15:0] sp_hi;
    logic [15:0] dp_lo;
    logic [15:0] dp_hi;
    logic [7:0]  pr_lo;
    logic [7:0]  pr_hi;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    rule_t            rule;
  } cmd_entry_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0]  l;
    logic [31:0] m;
    l = (len > 6'd32) ? 6'd32 : len;
    if (l == 6'd0) begin
      m = '0;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - l);
    end
    return m;
  endfunction

  function automatic logic rule_hit(input rule_t r, input rule_t key);
    logic a_ok;
    logic b_ok;
    logic sp_ok;
    logic dp_ok;
    logic pr_ok;
    a_ok  = ((key.src_addr ^ r.src_addr) & r.src_mask) == 32'd0;
    b_ok  = ((key.dst_addr ^ r.dst_addr) & r.dst_mask) == 32'd0;
    sp_ok = (key.sp_lo >= r.sp_lo) && (key.sp_lo <= r.sp_hi);
    dp_ok = (key.dp_lo >= r.dp_lo) && (key.dp_lo <= r.dp_hi);
    pr_ok = (key.pr_lo >= r.pr_lo) && (key.pr_lo <= r.pr_hi);
    return a_ok && b_ok && sp_ok && dp_ok && pr_ok;
  endfunction

endpackage

// ----- hdl/fmpc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fmpc_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the scan engine.
module fmpc_queue
  import fmpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output cmd_entry_t pop_data,
  output logic       empty
);

  cmd_entry_t           entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/fmpc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, decodes them and builds queue commands.
module fmpc_front
  import fmpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  in_item_t   in_item,
  output logic       in_full,
  output logic       q_push,
  output cmd_entry_t q_data,
  input  logic       q_full
);

  localparam int IDXC_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  logic       stage_valid_r, stage_valid_nxt;
  cmd_entry_t stage_r, stage_nxt;
  logic       accept;
  logic       keep;

  assign in_full = stage_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = stage_valid_r;
  assign q_data  = stage_r;

  always_comb begin
    stage_nxt.op            = op_t'(in_item.cmd);
    stage_nxt.idx           = IDX_W'(in_item.rule_index);
    stage_nxt.rule.src_addr = in_item.addr_a;
    stage_nxt.rule.dst_addr = in_item.addr_b;
    stage_nxt.rule.src_mask = prefix_mask(in_item.len_a);
    stage_nxt.rule.dst_mask = prefix_mask(in_item.len_b);
    stage_nxt.rule.sp_lo    = in_item.port_a_low;
    stage_nxt.rule.sp_hi    = in_item.port_a_high;
    stage_nxt.rule.dp_lo    = in_item.port_b_low;
    stage_nxt.rule.dp_hi    = in_item.port_b_high;
    stage_nxt.rule.pr_lo    = in_item.proto_low;
    stage_nxt.rule.pr_hi    = in_item.proto_high;
    // writes beyond the table are dropped here
    keep = (op_t'(in_item.cmd) == OP_CLASSIFY) ||
           (IDXC_W'(in_item.rule_index) < IDXC_W'(MAX_RULES));
    stage_valid_nxt = (stage_valid_r && q_full) || (accept && keep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- hdl/fmpc_scan.sv -----
`timescale 1ns / 1ps
// Back end: executes rule writes and scans the rule memory for classify.
module fmpc_scan
  import fmpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_rule_count,
  input  logic             q_empty,
  input  cmd_entry_t       q_data,
  output logic             q_pop,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output rule_t            ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  rule_t            ram_rdata,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_item
);

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] limit_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  rule_t            key_r, key_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             hit;
  logic             last;
  logic [CNT_W-1:0] cnt_plus1;
  logic             slot_free;

  assign cfg_ready = 1'b1;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign ram_waddr = q_data.idx;
  assign ram_wdata = q_data.rule;

  assign hit       = rule_hit(ram_rdata, key_r);
  assign cnt_plus1 = CNT_W'(cnt_r) + CNT_W'(1);
  assign last      = (cnt_plus1 == limit_r);
  assign slot_free = !out_valid_r || out_pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && q_data.op == OP_CLASSIFY) begin
          state_nxt = (limit_r == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = cnt_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            key_nxt             = q_data.rule;
            cnt_nxt             = '0;
            ram_raddr           = '0;
            res_nxt.found       = 1'b0;
            res_nxt.rule_number = '0;
          end
        end
      end
      ST_SCAN: begin
        // ram_rdata holds entry cnt_r; fetch the next one behind it
        if (hit) begin
          res_nxt.found       = 1'b1;
          res_nxt.rule_number = 9'(cnt_plus1);
        end else if (!last) begin
          cnt_nxt   = cnt_r + IDX_W'(1);
          ram_raddr = cnt_nxt;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= (CMP_W'(cfg_rule_count) > CMP_W'(MAX_RULES)) ?
                   CNT_W'(MAX_RULES) : CNT_W'(CMP_W'(cfg_rule_count));
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> CNT_W'(cnt_r) < limit_r)
    else $error("scan index beyond rule count");

  a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE && !q_empty)
    else $error("rule write outside idle");

  a_found_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.found == (out_r.rule_number != 9'd0)) || CNT_W > 9)
    else $error("found flag and rule number disagree");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_valid_r && !out_pop |=> state_r == ST_EMIT)
    else $error("result dropped while output slot busy");

endmodule

// ----- hdl/first_match_packet_classifier_core.sv -----
`timescale 1ns / 1ps
// Top level of the first-match packet classifier.
//
// A write transaction stores one rule and yields no result; a classify
// transaction yields one result with the first matching rule (1-based) or
// found low. Write transactions with rule_index at or beyond the table size
// are dropped. The front end registers and decodes each transaction into a
// two-entry command queue; the scan engine behind it takes one command at a
// time. A classify scans the rules in order up to and including the first
// hit, at most min(rule_count, 256) of them, and holds its result until the
// output slot is free; the rule memory has one read port and delivers one
// rule per cycle. rule_count is written through the cfg channel, which is
// always ready; write it only while no transaction is in flight. Rule
// entries must be written before a classify scans them.
module first_match_packet_classifier_core
  import fmpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_item_t         in_item,
  output logic             in_full,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_rule_count
);

  logic             fq_push, fq_full;
  cmd_entry_t       fq_data;
  logic             qs_pop, qs_empty;
  cmd_entry_t       qs_data;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rule_t            ram_wdata, ram_rdata;

  fmpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (fq_push),
    .q_data  (fq_data),
    .q_full  (fq_full)
  );

  fmpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (qs_pop),
    .pop_data  (qs_data),
    .empty     (qs_empty)
  );

  fmpc_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fmpc_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_rule_count (cfg_rule_count),
    .q_empty        (qs_empty),
    .q_data         (qs_data),
    .q_pop          (qs_pop),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item       (out_item)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the first-match packet classifier core.
module testbench;
  import fmpc_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 600;

  class classifier_scoreboard;
    in_item_t    rule_mem [MAX_RULES];
    int unsigned rule_count;
    out_item_t   expected_matches [$];
    int          mismatches;

    function new();
      rule_count = 0;
      mismatches = 0;
      foreach (rule_mem[i]) rule_mem[i] = '0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      rule_count = 32'(value);
    endfunction

    function logic [31:0] net_mask(logic [5:0] len);
      return ~(32'hFFFF_FFFF >> len);
    endfunction

    function bit in_span(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
      return (v >= lo) && (v <= hi);
    endfunction

    function out_item_t first_hit(in_item_t pkt);
      out_item_t   res;
      in_item_t    r;
      int unsigned lim;
      int unsigned i;
      res = '0;
      lim = (rule_count > MAX_RULES) ? MAX_RULES : rule_count;
      for (i = 0; i < lim; i++) begin
        r = rule_mem[i];
        if (in_span(pkt.port_a_low, r.port_a_low, r.port_a_high) &&
            in_span(pkt.port_b_low, r.port_b_low, r.port_b_high) &&
            in_span({8'h0, pkt.proto_low}, {8'h0, r.proto_low}, {8'h0, r.proto_high}) &&
            (((pkt.addr_a ^ r.addr_a) & net_mask(r.len_a)) == 32'h0) &&
            (((pkt.addr_b ^ r.addr_b) & net_mask(r.len_b)) == 32'h0)) begin
          res.found       = 1'b1;
          res.rule_number = 9'(i + 1);
          return res;
        end
      end
      return res;
    endfunction

    function void note_input(in_item_t it);
      in_item_t r;
      if (op_t'(it.cmd) == OP_WRITE) begin
        if (it.rule_index < MAX_RULES) begin
          r = it;
          // lengths past 32 saturate when the rule is stored
          r.len_a = (it.len_a > 6'd32) ? 6'd32 : it.len_a;
          r.len_b = (it.len_b > 6'd32) ? 6'd32 : it.len_b;
          rule_mem[it.rule_index] = r;
        end
      end else begin
        expected_matches.push_back(first_hit(it));
      end
    endfunction

    function void flag(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected found=%0d rule=%0d, got found=%0d rule=%0d",
                 $realtime, what, want.found, want.rule_number, got.found, got.rule_number);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_matches.size() == 0) begin
        flag("result with nothing pending", '0, got);
        return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found || got.rule_number !== want.rule_number)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_push;
  in_item_t         in_item;
  logic             in_full;
  logic             out_empty;
  logic             out_pop;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_rule_count;

  classifier_scoreboard match_sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int stall_cycles;

  first_match_packet_classifier_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_item        (in_item),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_rule_count (cfg_rule_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Each call starts and ends just after a falling edge; push stays high for
  // the next call to decide, so it is never lowered and raised in one step.
  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_full);
    match_sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_push = 1'b0;
    while (match_sb.expected_matches.size() != 0) @(posedge clk);
    // trailing writes give no result but may still be in the engine
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] value);
    cfg_valid      = 1'b1;
    cfg_rule_count = value;
    do @(posedge clk); while (!cfg_ready);
    match_sb.set_count(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t noise_item();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t make_rule(
      logic [7:0] idx, logic [31:0] sa, logic [5:0] la, logic [31:0] da, logic [5:0] lb,
      logic [15:0] splo, logic [15:0] sphi, logic [15:0] dplo, logic [15:0] dphi,
      logic [7:0] prlo, logic [7:0] prhi);
    in_item_t it;
    it = '{cmd: OP_WRITE, rule_index: idx, addr_a: sa, addr_b: da, len_a: la, len_b: lb,
           port_a_low: splo, port_a_high: sphi, port_b_low: dplo, port_b_high: dphi,
           proto_low: prlo, proto_high: prhi};
    return it;
  endfunction

  // Fields that classify ignores are left random.
  function automatic in_item_t make_packet(logic [31:0] sa, logic [31:0] da,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [7:0] pr);
    in_item_t it;
    it            = noise_item();
    it.cmd        = OP_CLASSIFY;
    it.addr_a     = sa;
    it.addr_b     = da;
    it.port_a_low = sp;
    it.port_b_low = dp;
    it.proto_low  = pr;
    return it;
  endfunction

  function automatic logic [5:0] rand_len();
    case ($urandom_range(7))
      0:       return 6'd0;
      1:       return 6'd32;
      2:       return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic void rand_span(input int unsigned top, output int unsigned lo,
                                    output int unsigned hi);
    case ($urandom_range(9))
      0: begin
        lo = $urandom_range(1, top);
        hi = lo - 1;
      end
      1: begin
        lo = 0;
        hi = top;
      end
      2: begin
        lo = $urandom_range(top);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(top);
        hi = $urandom_range(lo, top);
      end
    endcase
  endfunction

  function automatic in_item_t rand_rule(logic [7:0] idx);
    int unsigned sl, sh, dl, dh, pl, ph;
    rand_span(16'hFFFF, sl, sh);
    rand_span(16'hFFFF, dl, dh);
    rand_span(8'hFF, pl, ph);
    return make_rule(idx, $urandom, rand_len(), $urandom, rand_len(),
                     16'(sl), 16'(sh), 16'(dl), 16'(dh), 8'(pl), 8'(ph));
  endfunction

  // Value in or near the range: on each bound, just past it, or inside; any value for an empty range.
  function automatic int unsigned pick_near(int unsigned lo, int unsigned hi,
                                            int unsigned top);
    if (lo > hi) return $urandom_range(top);
    case ($urandom_range(5))
      0:       return lo;
      1:       return hi;
      2:       return (lo == 0) ? top : lo - 1;
      3:       return (hi == top) ? 0 : hi + 1;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic in_item_t packet_for(in_item_t r);
    logic [31:0] ma, mb, sa, da;
    ma = match_sb.net_mask(r.len_a);
    mb = match_sb.net_mask(r.len_b);
    sa = (r.addr_a & ma) | ($urandom & ~ma);
    da = (r.addr_b & mb) | ($urandom & ~mb);
    if ($urandom_range(7) == 0) sa ^= 32'h1 << $urandom_range(31);
    if ($urandom_range(7) == 0) da ^= 32'h1 << $urandom_range(31);
    return make_packet(sa, da,
                       16'(pick_near(r.port_a_low, r.port_a_high, 16'hFFFF)),
                       16'(pick_near(r.port_b_low, r.port_b_high, 16'hFFFF)),
                       8'(pick_near(r.proto_low, r.proto_high, 8'hFF)));
  endfunction

  function automatic in_item_t rand_item();
    int unsigned lim;
    int unsigned k;
    if ($urandom_range(4) == 0) return rand_rule(8'($urandom));
    if ($urandom_range(3) == 0) begin
      return make_packet($urandom, $urandom, 16'($urandom), 16'($urandom),
                         8'($urandom));
    end
    lim = (match_sb.rule_count > MAX_RULES) ? MAX_RULES : match_sb.rule_count;
    k   = (lim == 0) ? $urandom_range(MAX_RULES - 1) : $urandom_range(lim - 1);
    return packet_for(match_sb.rule_mem[k]);
  endfunction

  // Result side: random pops, plus a long hold-off when requested.
  initial begin
    int n;
    out_pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        out_pop  = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_pop = ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (out_pop && !out_empty) match_sb.check_result(out_item);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase_counts [PHASES];
    int cnt;
    phase_counts   = '{256, 511, 1, -1, 0, 255, -1, 256, -1};
    match_sb       = new();
    tx_idle_pct    = 32;
    rx_idle_pct    = 69;
    hold_req       = 0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_rule_count = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table
    configure(9'd0);
    push_item(make_packet(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    push_item(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF));

    // empty range, saturated length, wildcard and exact prefixes, catch-all
    push_item(make_rule(8'd0, 32'h0, 6'd0, 32'h0, 6'd0,
                        16'd100, 16'd99, 16'h0, 16'hFFFF, 8'h00, 8'hFF));
    push_item(make_rule(8'd1, 32'hC0A8_0001, 6'd63, 32'h0A00_0001, 6'd32,
                        16'd80, 16'd80, 16'd1024, 16'hFFFF, 8'd6, 8'd6));
    push_item(make_rule(8'd2, 32'hAC10_0000, 6'd12, 32'h1234_5678, 6'd0,
                        16'h0, 16'hFFFF, 16'h0, 16'h0, 8'd17, 8'd17));
    push_item(make_rule(8'd3, 32'h8000_0000, 6'd1, 32'hFFFF_FFFE, 6'd31,
                        16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 8'hFF, 8'hFF));
    push_item(make_rule(8'd4, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 6'd0,
                        16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 8'h00, 8'hFF));
    push_item(make_rule(8'd5, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    wait_idle();
    configure(9'd6);
    push_item(make_packet(32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1024, 8'd6));
    push_item(make_packet(32'hC0A8_0001, 32'h0A00_0001, 16'd81, 16'd1024, 8'd6));
    push_item(make_packet(32'hAC1F_FFFF, $urandom, 16'd5, 16'd0, 8'd17));
    push_item(make_packet(32'h8765_4321, 32'hFFFF_FFFF, 16'hFFFF, 16'd7, 8'hFF));
    push_item(make_packet(32'h0, 32'h0, 16'd100, 16'h0, 8'h0));
    push_item(make_packet(32'h0, 32'h0, 16'd99, 16'h0, 8'h0));
    wait_idle();
    configure(9'd4);
    push_item(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_item(make_packet(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    push_item(make_packet(32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1023, 8'd6));
    wait_idle();

    // fill the whole table so any rule count is legal from here on
    for (int i = 0; i < MAX_RULES; i++) push_item(rand_rule(8'(i)));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      cnt = (phase_counts[p] < 0) ? $urandom_range(511) : phase_counts[p];
      configure(CFG_W'(cnt));
      // receiver backs off while items keep coming, so the input stalls
      if (p == 0 || p == 4) hold_req = HOLD_CYCLES;
      for (int j = 0; j < PHASE_ITEMS; j++) push_item(rand_item());
      wait_idle();
    end

    if (match_sb.mismatches == 0 && match_sb.expected_matches.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- first_match_packet_classifier_core.f -----
hdl/fmpc_pkg.sv
hdl/fmpc_ram.sv
hdl/fmpc_queue.sv
hdl/fmpc_front.sv
hdl/fmpc_scan.sv
hdl/first_match_packet_classifier_core.sv
dv/testbench.sv
